// File: hdl/int_to_decimal_ascii_padded_top_defines.svh
// Assertion macros for the decimal text formatter.
`ifndef INT_TO_DECIMAL_ASCII_PADDED_TOP_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_PADDED_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define ITDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define ITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ITDA_ASSERT_NOW(lbl, ante, cons, msg)
`define ITDA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/itda_pkg.sv
// Shared constants and types of the decimal text formatter.
package itda_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned PAD_BITS       = 7;
  localparam int unsigned MAX_CHARS      = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    SEL_SPACE,
    SEL_MINUS,
    SEL_DIGIT
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      dabble;
    logic      scan;
    logic      plan;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic bits_done;
    logic top_zero;
    logic ndig_one;
    logic pads_zero;
    logic pads_one;
    logic neg;
    logic pneg;
    logic slot_free;
  } status_t;

endpackage

// File: hdl/itda_in_if.sv
// Input channel interface: integer value and justification width.
interface itda_in_if import itda_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic signed [PAD_BITS-1:0]   pad_width;

  modport source (output valid, value, pad_width, input ready);
  modport sink   (input valid, value, pad_width, output ready);
endinterface

// File: hdl/itda_out_if.sv
// Output channel interface: one ASCII character with its last flag.
interface itda_out_if import itda_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

// File: hdl/itda_ctrl.sv
// Sequencer that steps the formatter datapath through conversion and output.
module itda_ctrl import itda_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DECIDE,
    ST_LEAD,
    ST_SIGN,
    ST_DIGIT,
    ST_TRAIL
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.sel = SEL_SPACE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
        if (sts_i.bits_done) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // Drop leading zero digits, always keeping at least one.
        if (sts_i.top_zero && !sts_i.ndig_one) begin
          cmd.scan = 1'b1;
        end else begin
          cmd.plan = 1'b1;
          state_d  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!sts_i.pneg && !sts_i.pads_zero) state_d = ST_LEAD;
        else if (sts_i.neg)                  state_d = ST_SIGN;
        else                                 state_d = ST_DIGIT;
      end
      ST_LEAD: begin
        if (sts_i.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_SPACE;
          if (sts_i.pads_one) state_d = sts_i.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts_i.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_MINUS;
          state_d  = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_DIGIT;
          cmd.last = sts_i.ndig_one && (!sts_i.pneg || sts_i.pads_zero);
          if (sts_i.ndig_one) begin
            state_d = (sts_i.pneg && !sts_i.pads_zero) ? ST_TRAIL : ST_IDLE;
          end
        end
      end
      ST_TRAIL: begin
        if (sts_i.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_SPACE;
          cmd.last = sts_i.pads_one;
          if (sts_i.pads_one) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o      = cmd;

endmodule

// File: hdl/itda_dp.sv
// Datapath: magnitude, shift-add-3 BCD converter, counters and output register.
module itda_dp import itda_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic signed [PAD_BITS-1:0]   pad_width_i,
  input  cmd_t                         cmd_i,
  output status_t                      sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [7:0]                   character_o,
  output logic                         last_o
);

  // Digit count is a safe upper bound on the decimal length of 2^VALUE_BITS.
  localparam int unsigned NDIG   = (VALUE_BITS * 3) / 10 + 2;
  localparam int unsigned BCD_W  = 4 * NDIG;
  localparam int unsigned NDIG_W = $clog2(NDIG + 1);
  localparam int unsigned BIT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned PMAG_W = $clog2(MAX_CHARS + 1);
  localparam int unsigned LEN_W  = $clog2(NDIG + 2);
  localparam int unsigned CMP_W  = (PMAG_W > LEN_W) ? PMAG_W : LEN_W;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_load;
  logic [PAD_BITS-1:0]   praw;
  logic [PAD_BITS-1:0]   pabs;
  logic [PMAG_W-1:0]     psat;
  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            top_digit;
  logic [CMP_W-1:0]      len;
  logic [CMP_W-1:0]      pmag_ext;
  logic [7:0]            char_sel;

  logic [VALUE_BITS-1:0] mag_q;
  logic [BCD_W-1:0]      bcd_q;
  logic [BIT_W-1:0]      bit_cnt_q;
  logic [NDIG_W-1:0]     ndig_q;
  logic [PMAG_W-1:0]     pmag_q;
  logic [PMAG_W-1:0]     pads_q;
  logic                  neg_q;
  logic                  pneg_q;
  logic                  ovalid_q;
  logic [7:0]            char_q;
  logic                  last_q;

  // The most negative value negates to itself, which read unsigned is 2^(N-1).
  assign raw      = value_i;
  assign mag_load = raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + 1'b1) : raw;
  assign praw     = pad_width_i;
  assign pabs     = praw[PAD_BITS-1] ? PAD_BITS'(~praw + 1'b1) : praw;
  assign psat     = (pabs > PAD_BITS'(MAX_CHARS)) ? PMAG_W'(MAX_CHARS) : PMAG_W'(pabs);

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                      : bcd_q[4*i +: 4];
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign len       = CMP_W'(ndig_q) + CMP_W'(neg_q);
  assign pmag_ext  = CMP_W'(pmag_q);

  always_comb begin
    case (cmd_i.sel)
      SEL_SPACE: char_sel = CHAR_SPACE;
      SEL_MINUS: char_sel = CHAR_MINUS;
      SEL_DIGIT: char_sel = CHAR_ZERO + {4'd0, top_digit};
      default:   char_sel = CHAR_SPACE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q     <= mag_load;
      bcd_q     <= '0;
      bit_cnt_q <= BIT_W'(VALUE_BITS);
      ndig_q    <= NDIG_W'(NDIG);
      neg_q     <= raw[VALUE_BITS-1];
      pneg_q    <= praw[PAD_BITS-1];
      pmag_q    <= psat;
    end else if (cmd_i.dabble) begin
      bcd_q     <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
      mag_q     <= {mag_q[VALUE_BITS-2:0], 1'b0};
      bit_cnt_q <= bit_cnt_q - 1'b1;
    end else if (cmd_i.scan || (cmd_i.emit && cmd_i.sel == SEL_DIGIT)) begin
      bcd_q     <= {bcd_q[BCD_W-5:0], 4'd0};
      ndig_q    <= ndig_q - 1'b1;
    end
    if (cmd_i.plan) begin
      pads_q <= (pmag_ext > len) ? PMAG_W'(pmag_ext - len) : '0;
    end else if (cmd_i.emit && cmd_i.sel == SEL_SPACE) begin
      pads_q <= pads_q - 1'b1;
    end
    if (cmd_i.emit) begin
      char_q <= char_sel;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign sts_o.bits_done = (bit_cnt_q == BIT_W'(1));
  assign sts_o.top_zero  = (top_digit == 4'd0);
  assign sts_o.ndig_one  = (ndig_q == NDIG_W'(1));
  assign sts_o.pads_zero = (pads_q == '0);
  assign sts_o.pads_one  = (pads_q == PMAG_W'(1));
  assign sts_o.neg       = neg_q;
  assign sts_o.pneg      = pneg_q;
  assign sts_o.slot_free = !ovalid_q || out_ready_i;

  assign out_valid_o = ovalid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

// File: hdl/int_to_decimal_ascii_padded_top.sv
// Top level of the decimal text formatter with space justification.
//
// Usage: an input transaction on in_i carries a signed value and a signed
// pad_width. The block answers with a stream of output transactions on out_o,
// one ASCII character each, most significant character first: optional
// leading spaces (positive width), a minus sign for negative values, the
// decimal digits, optional trailing spaces (negative width). The last flag
// marks the final character. Width magnitudes above 32 saturate to 32; text
// longer than the width is never cut.
// Timing: after acceptance the binary magnitude goes through a shift-add-3
// converter, one bit per cycle, then leading zero digits are dropped one per
// cycle, then the padding is set up and the first character is picked.
// Characters then leave at one per cycle while out_o.ready stays high. One
// item is handled at a time; in_i is ready again as soon as the last
// character sits in the output register.
// Reset empties the output register and returns the sequencer to idle. A
// stalled receiver simply holds the current character and freezes the
// sequencer in its character states until out_o.ready returns.
`include "int_to_decimal_ascii_padded_top_defines.svh"
module int_to_decimal_ascii_padded_top import itda_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  itda_in_if.sink           in_i,
  itda_out_if.source        out_o
);

  // Command and status bundles between the sequencer and the datapath.
  cmd_t    cmd;
  status_t sts;
  logic    in_ready;

  itda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itda_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .pad_width_i (in_i.pad_width),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .character_o (out_o.character),
    .last_o      (out_o.last)
  );

  assign in_i.ready = in_ready;

  // An accepted input transaction must start a conversion.
  `ITDA_ASSERT_NOW(a_accept_loads, in_i.valid && in_i.ready, cmd.load, "accept without load")
  // Once a conversion starts, no further input is taken.
  `ITDA_ASSERT_NEXT(a_busy_after_load, cmd.load, !in_i.ready, "input ready during work")
  // A character is only written into a free output register.
  `ITDA_ASSERT_NOW(a_emit_slot_free, cmd.emit, sts.slot_free, "output overwritten")
  // Every written character is presented on the output channel.
  `ITDA_ASSERT_NEXT(a_emit_shows, cmd.emit, out_o.valid, "character not presented")

endmodule

// File: verif/itda_scoreboard.sv
// Checker for the decimal text formatter: predicts each character stream and compares it.
module itda_scoreboard import itda_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [VALUE_BITS-1:0] in_value_i,
  input  logic [PAD_BITS-1:0]   in_pad_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [7:0]            out_char_i,
  input  logic                  out_last_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } ascii_beat_t;

  ascii_beat_t expected_text_q[$];
  int          fails = 0;
  int          pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Builds the justified decimal text of one value and queues it, one beat per character.
  task automatic queue_decimal_text(input logic [VALUE_BITS-1:0] value,
                                    input logic [PAD_BITS-1:0] pad);
    logic [VALUE_BITS-1:0] mag;
    logic [7:0]            digits[$];
    logic [7:0]            line[$];
    logic                  neg;
    logic                  pad_left;
    int                    width;
    int                    text_len;
    int                    pads;
    ascii_beat_t           beat;
    neg = value[VALUE_BITS-1];
    // The most negative value wraps back onto itself, which read unsigned is 2^(N-1).
    mag = neg ? (~value + 1'b1) : value;
    pad_left = !pad[PAD_BITS-1];
    width = pad_left ? int'(pad) : (2 ** PAD_BITS) - int'(pad);
    if (width > MAX_CHARS) width = MAX_CHARS;
    if (mag == '0) begin
      digits.push_front(CHAR_ZERO);
    end else begin
      while (mag != '0) begin
        digits.push_front(CHAR_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end
    end
    text_len = digits.size() + (neg ? 1 : 0);
    pads = (width > text_len) ? width - text_len : 0;
    if (pad_left) repeat (pads) line.push_back(CHAR_SPACE);
    if (neg) line.push_back(CHAR_MINUS);
    foreach (digits[i]) line.push_back(digits[i]);
    if (!pad_left) repeat (pads) line.push_back(CHAR_SPACE);
    foreach (line[i]) begin
      beat.character = line[i];
      beat.last      = (i == line.size() - 1);
      expected_text_q.push_back(beat);
    end
  endtask

  always @(posedge clk_i) begin
    ascii_beat_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_text_q.size() == 0) begin
          $error("unexpected character %h (last %b) with no conversion pending",
                 out_char_i, out_last_i);
          fails++;
        end else begin
          want = expected_text_q.pop_front();
          if (out_char_i !== want.character) begin
            $error("character mismatch: expected %h, actual %h", want.character, out_char_i);
            fails++;
          end
          if (out_last_i !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, out_last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) queue_decimal_text(in_value_i, in_pad_i);
      pending = expected_text_q.size();
    end
  end

endmodule

// File: verif/tb.sv
// Testbench top of the decimal text formatter: clock, reset, stimulus and verdict.
module tb;
  import itda_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VB           = VALUE_BITS_DEF;
  localparam int          RANDOM_ITEMS = 480;
  // Length of the one long receiver hold-off that backs the block up onto its input.
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_LIMIT  = 20000;
  // Well above the longest unstalled conversion; used as the quiet period at the end.
  localparam int          TAIL_CYCLES  = 120;

  // Receiver stall styles; each one runs for a random segment of cycles.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PULSE
  } rx_style_e;

  logic clk_i;
  logic rst_ni;
  logic hold_go;
  int   fail_count;
  int   pending;
  int   burst_left;

  itda_in_if #(.VALUE_BITS(VB)) in_bus ();
  itda_out_if                   out_bus ();

  int_to_decimal_ascii_padded_top #(.VALUE_BITS(VB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  itda_scoreboard #(.VALUE_BITS(VB)) u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_bus.valid),
    .in_ready_i   (in_bus.ready),
    .in_value_i   (in_bus.value),
    .in_pad_i     (in_bus.pad_width),
    .out_valid_i  (out_bus.valid),
    .out_ready_i  (out_bus.ready),
    .out_char_i   (out_bus.character),
    .out_last_i   (out_bus.last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs. This is far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Offers one conversion and holds it until the block takes it. The sender works in
  // bursts: valid stays high across items inside a burst, and after a burst ends it drops
  // for a random gap. Valid is never lowered and raised in the same time step.
  task automatic send_conversion(input logic [VB-1:0] value, input logic [PAD_BITS-1:0] pad);
    int gap;
    in_bus.valid     <= 1'b1;
    in_bus.value     <= value;
    in_bus.pad_width <= pad;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_bus.valid <= 1'b0;
      gap = $urandom_range(12, 1);
      repeat (gap) @(posedge clk_i);
      // About one burst in four is long, so there are stretches without any idling.
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 15) : $urandom_range(6);
    end
  endtask

  // Picks a value so that every digit count is well represented, not only ten-digit ones.
  function automatic logic [VB-1:0] pick_value();
    logic [VB-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(999);
      2: v = -$urandom_range(999);
      3: begin
        v = $urandom >> $urandom_range(VB - 1);
        if ($urandom_range(1)) v = -v;
      end
      4: begin
        case ($urandom_range(3))
          0: v = {1'b1, {(VB-1){1'b0}}};
          1: v = {1'b0, {(VB-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly widths in the nominal range; some full-range codes to hit the saturation.
  function automatic logic [PAD_BITS-1:0] pick_pad();
    logic [PAD_BITS-1:0] p;
    case ($urandom_range(9))
      7: p = PAD_BITS'($urandom);
      8: p = '0;
      9: begin
        case ($urandom_range(5))
          0: p = PAD_BITS'(32);
          1: p = PAD_BITS'(-32);
          2: p = PAD_BITS'(33);
          3: p = PAD_BITS'(-33);
          4: p = PAD_BITS'(63);
          default: p = PAD_BITS'(-64);
        endcase
      end
      default: p = PAD_BITS'(int'($urandom_range(64)) - 32);
    endcase
    return p;
  endfunction

  // Receiver. It stalls according to a style that changes every segment, and once, when
  // the random phase starts, it holds ready low for a long stretch while the sender keeps
  // offering items. Since the block converts one item at a time, that stall backs up into
  // the input and keeps in_bus.ready low.
  initial begin
    int        seg_left;
    int        hold_left;
    int        phase;
    bit        held;
    rx_style_e style;
    out_bus.ready <= 1'b0;
    seg_left  = 0;
    hold_left = 0;
    phase     = 0;
    held      = 1'b0;
    style     = RX_OPEN;
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          style    = rx_style_e'($urandom_range(3));
          seg_left = $urandom_range(200, 20);
        end
        seg_left--;
        phase++;
        case (style)
          RX_OPEN:   out_bus.ready <= 1'b1;
          RX_COIN:   out_bus.ready <= 1'($urandom_range(1));
          RX_SPARSE: out_bus.ready <= ($urandom_range(3) == 0);
          default:   out_bus.ready <= ((phase % 8) < 3);
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int waited;
    rst_ni           = 1'b0;
    hold_go          <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.value     <= '0;
    in_bus.pad_width <= '0;
    burst_left       = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zero, the extremes of both fields, the most negative value with its
    // unsigned magnitude, widths shorter than the text, and widths that saturate at 32.
    send_conversion(VB'(0), PAD_BITS'(0));
    send_conversion(VB'(0), PAD_BITS'(1));
    send_conversion(VB'(0), PAD_BITS'(32));
    send_conversion(VB'(0), PAD_BITS'(-32));
    send_conversion(VB'(1), PAD_BITS'(0));
    send_conversion(VB'(-1), PAD_BITS'(0));
    send_conversion(VB'(9), PAD_BITS'(2));
    send_conversion(VB'(10), PAD_BITS'(-3));
    send_conversion(VB'(-10), PAD_BITS'(5));
    send_conversion({1'b0, {(VB-1){1'b1}}}, PAD_BITS'(0));
    send_conversion({1'b1, {(VB-1){1'b0}}}, PAD_BITS'(0));
    send_conversion({1'b1, {(VB-1){1'b0}}}, PAD_BITS'(32));
    send_conversion({1'b1, {(VB-1){1'b0}}}, PAD_BITS'(-32));
    send_conversion({1'b0, {(VB-1){1'b1}}}, PAD_BITS'(5));
    send_conversion(VB'(-999999999), PAD_BITS'(-4));
    send_conversion(VB'(1000000000), PAD_BITS'(11));
    send_conversion(VB'(123), PAD_BITS'(33));
    send_conversion(VB'(123), PAD_BITS'(63));
    send_conversion(VB'(-123), PAD_BITS'(-33));
    send_conversion(VB'(-123), PAD_BITS'(-64));
    send_conversion(VB'(42), PAD_BITS'(-1));
    send_conversion(VB'(-7), PAD_BITS'(-2));
    send_conversion(VB'(-1), PAD_BITS'(63));

    // Random part. The long receiver hold-off starts with it.
    hold_go <= 1'b1;
    repeat (RANDOM_ITEMS) send_conversion(pick_value(), pick_pad());
    in_bus.valid <= 1'b0;

    // Let the last accepted item reach the checker before looking at what is left.
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    // A quiet period catches any stray character the block might still emit.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/itda_pkg.sv
hdl/itda_in_if.sv
hdl/itda_out_if.sv
hdl/itda_ctrl.sv
hdl/itda_dp.sv
hdl/int_to_decimal_ascii_padded_top.sv
verif/itda_scoreboard.sv
verif/tb.sv
